// ----- hdl/hpx_pkg.sv -----
// Shared constants, types and tables for the nested pixel to angle pipeline.
package hpx_pkg;

  localparam int unsigned NSIDE = 64;
  localparam int unsigned ORD = 6;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned FACE_W = 4;
  localparam int unsigned RA_W = 29;
  localparam int unsigned DEC_W = 28;
  localparam int unsigned RING_W = 8;

  localparam int unsigned PREP_STAGES = 3;
  localparam int unsigned DIV_STAGES = 29;
  localparam int unsigned SQRT_STAGES = 31;
  localparam int unsigned CORDIC_STAGES = 26;
  localparam int unsigned PIPE_STAGES = PREP_STAGES + SQRT_STAGES + CORDIC_STAGES;

  localparam int unsigned RAD_W = 62;
  localparam int unsigned REM_W = 33;
  localparam int unsigned ROOT_W = 31;
  localparam int unsigned XY_W = 34;
  localparam int unsigned ANG_W = 32;
  localparam int unsigned UA_W = 14;
  localparam int unsigned DVD_W = 36;
  localparam int unsigned DVS_W = 8;
  localparam int unsigned REMD_W = 7;

  localparam logic [27:0] B_SQ = 28'd150994944;
  localparam logic [DEC_W-1:0] DEC_MAX = 28'd94371840;
  localparam logic [FACE_W-1:0] FACE_BAD = 4'd15;
  localparam logic [FACE_W-1:0] FACE_CNT = 4'd12;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [RING_W-1:0] ring;
    logic              neg;
    logic              zero;
    logic              bad;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [UA_W-1:0]  ua;
    logic [27:0]      d;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } prep_t;

  function automatic logic [2:0] face_row(input logic [FACE_W-1:0] f);
    case (f)
      4'd0, 4'd1, 4'd2, 4'd3:   face_row = 3'd2;
      4'd4, 4'd5, 4'd6, 4'd7:   face_row = 3'd3;
      4'd8, 4'd9, 4'd10, 4'd11: face_row = 3'd4;
      default:                  face_row = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] face_col(input logic [FACE_W-1:0] f);
    case (f)
      4'd0, 4'd8:  face_col = 3'd1;
      4'd1, 4'd9:  face_col = 3'd3;
      4'd2, 4'd10: face_col = 3'd5;
      4'd3, 4'd11: face_col = 3'd7;
      4'd4:        face_col = 3'd0;
      4'd5:        face_col = 3'd2;
      4'd6:        face_col = 3'd4;
      4'd7:        face_col = 3'd6;
      default:     face_col = 3'd0;
    endcase
  endfunction

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic [29:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0:    atan_deg = 30'd754974720;
      5'd1:    atan_deg = 30'd445687602;
      5'd2:    atan_deg = 30'd235489088;
      5'd3:    atan_deg = 30'd119537938;
      5'd4:    atan_deg = 30'd60000934;
      5'd5:    atan_deg = 30'd30029717;
      5'd6:    atan_deg = 30'd15018523;
      5'd7:    atan_deg = 30'd7509720;
      5'd8:    atan_deg = 30'd3754917;
      5'd9:    atan_deg = 30'd1877466;
      5'd10:   atan_deg = 30'd938734;
      5'd11:   atan_deg = 30'd469367;
      5'd12:   atan_deg = 30'd234684;
      5'd13:   atan_deg = 30'd117342;
      5'd14:   atan_deg = 30'd58671;
      5'd15:   atan_deg = 30'd29335;
      5'd16:   atan_deg = 30'd14668;
      5'd17:   atan_deg = 30'd7334;
      5'd18:   atan_deg = 30'd3667;
      5'd19:   atan_deg = 30'd1833;
      5'd20:   atan_deg = 30'd917;
      5'd21:   atan_deg = 30'd458;
      5'd22:   atan_deg = 30'd229;
      5'd23:   atan_deg = 30'd115;
      5'd24:   atan_deg = 30'd57;
      5'd25:   atan_deg = 30'd29;
      default: atan_deg = 30'd0;
    endcase
  endfunction

endpackage

// ----- hdl/hpx_prep.sv -----
// Index decode: face, de-interleave, ring, position in ring, z numerator.
module hpx_prep (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [hpx_pkg::IDX_W-1:0]    pixel_index_i,
  output hpx_pkg::prep_t               prep_o
);
  import hpx_pkg::*;

  // first stage
  logic [FACE_W-1:0] face1_d, face1_q;
  logic [ORD-1:0]    ix1_d, ix1_q, iy1_d, iy1_q;
  logic [8:0]        jr1_d, jr1_q;
  logic              bad1_d, bad1_q;

  // second stage
  logic [6:0]         nr2_d, nr2_q;
  logic               ksh2_d, ksh2_q;
  logic               neg2_d, neg2_q;
  logic [UA_W-1:0]    ua2_d, ua2_q;
  logic signed [10:0] jp2_d, jp2_q;
  logic [FACE_W-1:0]  face2_q;
  logic [8:0]         jr2_q;
  logic               bad2_q;

  prep_t prep_d, prep_q;

  logic [2:0]         row;
  logic [2:0]         col;
  logic [12:0]        nrsq;
  logic [8:0]         prod;
  logic signed [10:0] v;
  logic signed [10:0] four;
  logic signed [10:0] jpa, jpb, m_s;
  logic [15:0]        m90;
  logic [27:0]        usq;

  always_comb begin
    face1_d = pixel_index_i[IDX_W-1 -: FACE_W];
    for (int i = 0; i < ORD; i++) begin
      ix1_d[i] = pixel_index_i[2*i];
      iy1_d[i] = pixel_index_i[2*i+1];
    end
    row    = face_row(face1_d);
    jr1_d  = {row, 6'b0} - 9'(ix1_d) - 9'(iy1_d) - 9'd1;
    bad1_d = (face1_d >= FACE_CNT);
  end

  always_comb begin
    ksh2_d = 1'b0;
    neg2_d = 1'b0;
    if (jr1_q < 9'd64) begin
      nr2_d = jr1_q[6:0];
    end else if (jr1_q > 9'd192) begin
      nr2_d  = 7'(9'd256 - jr1_q);
      neg2_d = 1'b1;
    end else begin
      nr2_d  = 7'd64;
      ksh2_d = jr1_q[0];
    end
    nrsq = 13'(nr2_d) * 13'(nr2_d);
    if (jr1_q < 9'd64 || jr1_q > 9'd192) begin
      ua2_d = 14'd12288 - 14'(nrsq);
    end else if (jr1_q <= 9'd128) begin
      ua2_d = {7'(9'd128 - jr1_q), 7'b0};
    end else begin
      ua2_d  = {7'(jr1_q - 9'd128), 7'b0};
      neg2_d = 1'b1;
    end
    col  = face_col(face1_q);
    prod = 9'(col) * 9'(nr2_d);
    v    = $signed(11'(prod)) + $signed(11'(ix1_q)) - $signed(11'(iy1_q)) + 11'sd1
         + $signed(11'(ksh2_d));
    // halve with truncation towards zero
    jp2_d = (v + $signed(11'(v[10]))) >>> 1;
  end

  always_comb begin
    four = $signed(11'({nr2_q, 2'b00}));
    jpa  = (jp2_q > four) ? jp2_q - four : jp2_q;
    jpb  = (jpa < 11'sd1) ? jpa + four : jpa;
    m_s  = (jpb <<< 1) - $signed(11'(ksh2_q)) - 11'sd1;
    m90  = 16'(m_s[9:0]) * 16'd90;
    usq  = 28'(ua2_q) * 28'(ua2_q);
    prep_d.side.face = face2_q;
    prep_d.side.ring = jr2_q[7:0];
    prep_d.side.neg  = neg2_q;
    prep_d.side.zero = (ua2_q == '0);
    prep_d.side.bad  = bad2_q;
    prep_d.ua        = ua2_q;
    prep_d.d         = B_SQ - usq;
    prep_d.dividend  = {m90, 13'b0, nr2_q};
    prep_d.divisor   = {1'b0, nr2_q} << 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      face1_q <= face1_d;
      ix1_q   <= ix1_d;
      iy1_q   <= iy1_d;
      jr1_q   <= jr1_d;
      bad1_q  <= bad1_d;
      nr2_q   <= nr2_d;
      ksh2_q  <= ksh2_d;
      neg2_q  <= neg2_d;
      ua2_q   <= ua2_d;
      jp2_q   <= jp2_d;
      face2_q <= face1_q;
      jr2_q   <= jr1_q;
      bad2_q  <= bad1_q;
      prep_q  <= prep_d;
    end
  end

  assign prep_o = prep_q;

endmodule

// ----- hdl/hpx_div_cell.sv -----
// One restoring division cell: one quotient bit per cell.
module hpx_div_cell (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [hpx_pkg::REMD_W-1:0]  rem_i,
  input  logic [hpx_pkg::RA_W-1:0]    work_i,
  input  logic [hpx_pkg::DVS_W-1:0]   dvs_i,
  output logic [hpx_pkg::REMD_W-1:0]  rem_o,
  output logic [hpx_pkg::RA_W-1:0]    work_o,
  output logic [hpx_pkg::DVS_W-1:0]   dvs_o
);
  import hpx_pkg::*;

  logic [REMD_W:0]   t;
  logic              ge;
  logic [REMD_W-1:0] rem_d, rem_q;
  logic [RA_W-1:0]   work_d, work_q;
  logic [DVS_W-1:0]  dvs_q;

  // shift dividend bits out of the top, quotient bits in at the bottom
  always_comb begin
    t      = {rem_i, work_i[RA_W-1]};
    ge     = (t >= dvs_i);
    rem_d  = ge ? REMD_W'(t - dvs_i) : REMD_W'(t);
    work_d = {work_i[RA_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      work_q <= work_d;
      dvs_q  <= dvs_i;
    end
  end

  assign rem_o  = rem_q;
  assign work_o = work_q;
  assign dvs_o  = dvs_q;

endmodule

// ----- hdl/hpx_sqrt_cell.sv -----
// One digit-by-digit square root cell: one root bit per cell.
module hpx_sqrt_cell (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [hpx_pkg::RAD_W-1:0]   rad_i,
  input  logic [hpx_pkg::REM_W-1:0]   rem_i,
  input  logic [hpx_pkg::ROOT_W-1:0]  root_i,
  output logic [hpx_pkg::RAD_W-1:0]   rad_o,
  output logic [hpx_pkg::REM_W-1:0]   rem_o,
  output logic [hpx_pkg::ROOT_W-1:0]  root_o
);
  import hpx_pkg::*;

  logic [REM_W+1:0]  t;
  logic [REM_W+1:0]  trial;
  logic              ge;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_d, rem_q;
  logic [ROOT_W-1:0] root_d, root_q;

  always_comb begin
    t      = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial  = (REM_W+2)'({root_i, 2'b01});
    ge     = (t >= trial);
    rem_d  = ge ? REM_W'(t - trial) : REM_W'(t);
    root_d = {root_i[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_i << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ----- hdl/hpx_cordic_cell.sv -----
// One vectoring CORDIC cell, angle accumulated in degrees.
module hpx_cordic_cell (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [4:0]                        shift_i,
  input  logic signed [hpx_pkg::XY_W-1:0]   x_i,
  input  logic signed [hpx_pkg::XY_W-1:0]   y_i,
  input  logic signed [hpx_pkg::ANG_W-1:0]  ang_i,
  output logic signed [hpx_pkg::XY_W-1:0]   x_o,
  output logic signed [hpx_pkg::XY_W-1:0]   y_o,
  output logic signed [hpx_pkg::ANG_W-1:0]  ang_o
);
  import hpx_pkg::*;

  logic signed [XY_W-1:0]  dx, dy;
  logic signed [ANG_W-1:0] at;
  logic signed [XY_W-1:0]  x_d, x_q, y_d, y_q;
  logic signed [ANG_W-1:0] ang_d, ang_q;

  // drive y towards zero
  always_comb begin
    dx = y_i >>> shift_i;
    dy = x_i >>> shift_i;
    at = $signed(ANG_W'(atan_deg(shift_i)));
    if (!y_i[XY_W-1]) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      ang_d = ang_i + at;
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      ang_d = ang_i - at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      ang_q <= ang_d;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign ang_o = ang_q;

endmodule

// ----- hdl/healpix_nested_pixel_to_angle.sv -----
// Nested pixel index at resolution 64 to pixel centre (RA, Dec), face and ring.
// Throughput: one item per cycle unless the output stalls; three decode stages, then
// 31 square root cells (29 division cells alongside) and 26 CORDIC cells.
// Backpressure at the output freezes every stage until the result is taken.
// Reset clears the valid flags of all stages and of the output; data is not reset.
module healpix_nested_pixel_to_angle (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [hpx_pkg::IDX_W-1:0]   pixel_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hpx_pkg::RA_W-1:0]    right_ascension_o,
  output logic signed [hpx_pkg::DEC_W-1:0] declination_o,
  output logic [hpx_pkg::FACE_W-1:0]  base_face_o,
  output logic [hpx_pkg::RING_W-1:0]  ring_number_o
);
  import hpx_pkg::*;

  localparam int unsigned RA_DLY = SQRT_STAGES + CORDIC_STAGES - DIV_STAGES;
  localparam int unsigned SIDE_DLY = SQRT_STAGES + CORDIC_STAGES;

  logic en;
  logic [PIPE_STAGES-1:0] vld_q;
  logic out_valid_q;

  prep_t prep;

  logic [REMD_W-1:0] drem [DIV_STAGES+1];
  logic [RA_W-1:0]   dwork [DIV_STAGES+1];
  logic [DVS_W-1:0]  ddvs [DIV_STAGES+1];

  logic [RAD_W-1:0]  srad [SQRT_STAGES+1];
  logic [REM_W-1:0]  srem [SQRT_STAGES+1];
  logic [ROOT_W-1:0] sroot [SQRT_STAGES+1];

  logic signed [XY_W-1:0]  cx [CORDIC_STAGES+1];
  logic signed [XY_W-1:0]  cy [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0] cang [CORDIC_STAGES+1];

  logic [RA_W-1:0] ra_dly_q [RA_DLY];
  side_t           side_dly_q [SIDE_DLY];
  logic [UA_W-1:0] ua_dly_q [SQRT_STAGES];

  logic signed [ANG_W-1:0] rnd;
  logic [DEC_W-1:0]        mag;
  side_t                   side_end;
  logic [RA_W-1:0]         ra_d, ra_q;
  logic [DEC_W-1:0]        dec_d, dec_q;
  logic [FACE_W-1:0]       face_d, face_q;
  logic [RING_W-1:0]       ring_d, ring_q;

  // advance the whole pipeline unless a result is held at the output
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  hpx_prep u_prep (
    .clk_i         (clk_i),
    .en_i          (en),
    .pixel_index_i (pixel_index_i),
    .prep_o        (prep)
  );

  assign drem[0]  = prep.dividend[DVD_W-1 -: REMD_W];
  assign dwork[0] = prep.dividend[RA_W-1:0];
  assign ddvs[0]  = prep.divisor;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    hpx_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (drem[k]),
      .work_i (dwork[k]),
      .dvs_i  (ddvs[k]),
      .rem_o  (drem[k+1]),
      .work_o (dwork[k+1]),
      .dvs_o  (ddvs[k+1])
    );
  end

  assign srad[0]  = {prep.d, (RAD_W-28)'(0)};
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    hpx_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (srad[k]),
      .rem_i  (srem[k]),
      .root_i (sroot[k]),
      .rad_o  (srad[k+1]),
      .rem_o  (srem[k+1]),
      .root_o (sroot[k+1])
    );
  end

  assign cx[0]   = $signed(XY_W'(sroot[SQRT_STAGES]));
  assign cy[0]   = $signed(XY_W'({ua_dly_q[SQRT_STAGES-1], 17'b0}));
  assign cang[0] = '0;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    hpx_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .shift_i (5'(k)),
      .x_i     (cx[k]),
      .y_i     (cy[k]),
      .ang_i   (cang[k]),
      .x_o     (cx[k+1]),
      .y_o     (cy[k+1]),
      .ang_o   (cang[k+1])
    );
  end

  // align quotient and side data with the CORDIC output, and |a| with the square root output
  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_dly_q[0]   <= dwork[DIV_STAGES];
      side_dly_q[0] <= prep.side;
      ua_dly_q[0]   <= prep.ua;
      for (int i = 1; i < RA_DLY; i++) ra_dly_q[i] <= ra_dly_q[i-1];
      for (int i = 1; i < SIDE_DLY; i++) side_dly_q[i] <= side_dly_q[i-1];
      for (int i = 1; i < SQRT_STAGES; i++) ua_dly_q[i] <= ua_dly_q[i-1];
    end
  end

  always_comb begin
    side_end = side_dly_q[SIDE_DLY-1];
    rnd      = (cang[CORDIC_STAGES] + 32'sd8) >>> 4;
    if (rnd < 0) begin
      mag = '0;
    end else if (rnd > $signed(ANG_W'(DEC_MAX))) begin
      mag = DEC_MAX;
    end else begin
      mag = DEC_W'(rnd);
    end
    ra_d   = ra_dly_q[RA_DLY-1];
    dec_d  = side_end.zero ? '0 : (side_end.neg ? DEC_W'(-mag) : mag);
    face_d = side_end.face;
    ring_d = side_end.ring;
    // drop to the invalid marker for an index beyond the sphere
    if (side_end.bad) begin
      ra_d   = '0;
      dec_d  = '0;
      face_d = FACE_BAD;
      ring_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[PIPE_STAGES-2:0], in_valid_i};
      out_valid_q <= vld_q[PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q   <= ra_d;
      dec_q  <= dec_d;
      face_q <= face_d;
      ring_q <= ring_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign right_ascension_o = ra_q;
  assign declination_o     = $signed(dec_q);
  assign base_face_o       = face_q;
  assign ring_number_o     = ring_q;

endmodule

// ----- hdl/hpx_checker.sv -----
// Port-level checks on the pixel to angle block, bound to the top level.
module hpx_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [hpx_pkg::IDX_W-1:0]   pixel_index_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [hpx_pkg::RA_W-1:0]    right_ascension_o,
  input logic signed [hpx_pkg::DEC_W-1:0] declination_o,
  input logic [hpx_pkg::FACE_W-1:0]  base_face_o,
  input logic [hpx_pkg::RING_W-1:0]  ring_number_o
);
  import hpx_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(right_ascension_o)
      && $stable(declination_o) && $stable(base_face_o) && $stable(ring_number_o))
    else $error("stalled result changed");

  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((ring_number_o == '0) == (base_face_o == FACE_BAD)))
    else $error("invalid marker inconsistent");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ring_number_o == '0 |-> right_ascension_o == '0 && declination_o == '0)
    else $error("invalid result carries an angle");

  a_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ring_number_o != '0 |-> base_face_o < FACE_CNT
      && right_ascension_o < RA_W'(29'd377487360))
    else $error("face or longitude out of range");

  a_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> declination_o <= $signed(DEC_MAX) && declination_o >= -$signed(DEC_MAX))
    else $error("declination beyond a pole");

endmodule

bind healpix_nested_pixel_to_angle hpx_checker u_hpx_checker (.*);
